>>> sv/hlfd_pkg.sv
// Shared types and constants for the host link frame deframer.
`default_nettype none

package hlfd_pkg;

   localparam int SearchLimitDefault = 64;

   localparam logic [7:0] PreambleZero = 8'h00;
   localparam logic [7:0] StartCode    = 8'hFF;
   localparam logic [7:0] TfiHostward  = 8'hD5;

   // Request kinds carried on req_tuser.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_BYTE  = 1'b1;

   typedef enum logic [3:0] {
      ST_DATA_OK   = 4'd0,
      ST_ACK       = 4'd1,
      ST_NACK      = 4'd2,
      ST_BAD_INV   = 4'd3,
      ST_NO_PREAMB = 4'd4,
      ST_LCS       = 4'd5,
      ST_TOO_LONG  = 4'd6,
      ST_TFI       = 4'd7,
      ST_DCS       = 4'd8
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_FIRST,
      PH_SEARCH,
      PH_LEN,
      PH_INV,
      PH_ACKPOST,
      PH_LCS,
      PH_TFI,
      PH_DATA,
      PH_DCS,
      PH_DATAPOST
   } phase_type;

   typedef struct packed {
      logic [7:0] frame_length;
      status_type status;
      logic       is_last;
      logic [7:0] payload_byte;
   } result_type;

endpackage

`default_nettype wire

>>> sv/host_link_frame_deframer_top.sv
// Host link frame deframer: preamble search, header checks and payload streaming.
// Latency: a result appears on rsp_* in the cycle after the byte that causes it.
// Throughput: one transaction per cycle unless rsp_tready stalls a held result;
// the FSM steps on each accepted byte; the result register refills as it drains.
// Reset (synchronous, active high) returns the parser to idle and empties the
// result register; received bytes are ignored until a start transaction.
`default_nettype none

module host_link_frame_deframer_top #(
   parameter int SEARCH_LIMIT = hlfd_pkg::SearchLimitDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] rx_byte, [15:8] capacity
   input  wire logic        req_tuser,   // [0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] payload_byte, [11:8] status,
                                         // [19:12] frame_length, [23:20] zero
   output logic             rsp_tlast    // is_last
);
   import hlfd_pkg::*;

   localparam logic [6:0] SearchMax = 7'(SEARCH_LIMIT);

   phase_type  phase_ff, phase_in;
   logic       prev_zero_ff, prev_zero_in;
   logic [6:0] search_count_ff, search_count_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] capacity_ff, capacity_in;

   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   logic       accept;
   logic [7:0] rx_byte;
   logic [7:0] rem_dec;
   logic [7:0] sum_add;
   logic       emit;
   result_type result;

   assign rx_byte    = req_tdata[7:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rem_dec    = remaining_ff - 8'd1;
   assign sum_add    = sum_ff + rx_byte;

   // Next state of the frame parser.
   always_comb begin
      phase_in        = phase_ff;
      prev_zero_in    = prev_zero_ff;
      search_count_in = search_count_ff;
      length_in       = length_ff;
      remaining_in    = remaining_ff;
      sum_in          = sum_ff;
      capacity_in     = capacity_ff;
      if (req_tuser == FUNC_START) begin
         capacity_in     = req_tdata[15:8];
         phase_in        = PH_FIRST;
         prev_zero_in    = 1'b0;
         search_count_in = '0;
         length_in       = '0;
         remaining_in    = '0;
         sum_in          = '0;
      end else begin
         case (phase_ff)
            PH_FIRST: begin
               prev_zero_in = (rx_byte == PreambleZero);
               phase_in     = PH_SEARCH;
            end
            PH_SEARCH: begin
               if (search_count_ff >= SearchMax) begin
                  phase_in = PH_IDLE;
               end else if (rx_byte == StartCode && prev_zero_ff) begin
                  phase_in = PH_LEN;
               end else begin
                  prev_zero_in    = (rx_byte == PreambleZero);
                  search_count_in = search_count_ff + 7'd1;
               end
            end
            PH_LEN: begin
               length_in = rx_byte;
               phase_in  = (rx_byte == PreambleZero || rx_byte == StartCode) ? PH_INV : PH_LCS;
            end
            PH_INV: begin
               phase_in = (rx_byte == ~length_ff) ? PH_ACKPOST : PH_IDLE;
            end
            PH_ACKPOST: phase_in = PH_IDLE;
            PH_LCS: begin
               if (8'(length_ff + rx_byte) != 8'd0) begin
                  phase_in = PH_IDLE;
               end else begin
                  remaining_in = length_ff - 8'd1;
                  phase_in     = (length_ff - 8'd1 > capacity_ff) ? PH_IDLE : PH_TFI;
               end
            end
            PH_TFI: begin
               if (rx_byte != TfiHostward) begin
                  phase_in = PH_IDLE;
               end else begin
                  sum_in   = TfiHostward;
                  phase_in = (remaining_ff == 8'd0) ? PH_DCS : PH_DATA;
               end
            end
            PH_DATA: begin
               sum_in       = sum_add;
               remaining_in = rem_dec;
               if (rem_dec == 8'd0) begin
                  phase_in = PH_DCS;
               end
            end
            PH_DCS: begin
               sum_in   = sum_add;
               phase_in = (sum_add != 8'd0) ? PH_IDLE : PH_DATAPOST;
            end
            PH_DATAPOST: phase_in = PH_IDLE;
            default:     phase_in = PH_IDLE;
         endcase
      end
   end

   // Result produced by the byte in hand, if any.
   always_comb begin
      emit                = 1'b0;
      result.payload_byte = '0;
      result.is_last      = 1'b1;
      result.status       = ST_DATA_OK;
      result.frame_length = '0;
      if (req_tuser == FUNC_BYTE) begin
         case (phase_ff)
            PH_SEARCH: begin
               if (search_count_ff >= SearchMax) begin
                  emit          = 1'b1;
                  result.status = ST_NO_PREAMB;
               end
            end
            PH_INV: begin
               if (rx_byte != ~length_ff) begin
                  emit          = 1'b1;
                  result.status = ST_BAD_INV;
               end
            end
            PH_ACKPOST: begin
               emit          = 1'b1;
               result.status = (length_ff == PreambleZero) ? ST_ACK : ST_NACK;
            end
            PH_LCS: begin
               if (8'(length_ff + rx_byte) != 8'd0) begin
                  emit          = 1'b1;
                  result.status = ST_LCS;
               end else if (length_ff - 8'd1 > capacity_ff) begin
                  emit          = 1'b1;
                  result.status = ST_TOO_LONG;
               end
            end
            PH_TFI: begin
               if (rx_byte != TfiHostward) begin
                  emit          = 1'b1;
                  result.status = ST_TFI;
               end
            end
            PH_DATA: begin
               emit                = 1'b1;
               result.is_last      = 1'b0;
               result.payload_byte = rx_byte;
            end
            PH_DCS: begin
               if (sum_add != 8'd0) begin
                  emit          = 1'b1;
                  result.status = ST_DCS;
               end
            end
            PH_DATAPOST: begin
               emit                = 1'b1;
               result.frame_length = length_ff - 8'd1;
            end
            default: emit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         prev_zero_ff    <= 1'b0;
         search_count_ff <= '0;
         length_ff       <= '0;
         remaining_ff    <= '0;
         sum_ff          <= '0;
         capacity_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff        <= phase_in;
            prev_zero_ff    <= prev_zero_in;
            search_count_ff <= search_count_in;
            length_ff       <= length_in;
            remaining_ff    <= remaining_in;
            sum_ff          <= sum_in;
            capacity_ff     <= capacity_in;
         end
         if (req_tready) begin
            rsp_valid_ff <= accept && emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_data_ff.is_last;
   assign rsp_tdata  = {4'd0, rsp_data_ff.frame_length, rsp_data_ff.status,
                        rsp_data_ff.payload_byte};

endmodule

`default_nettype wire

>>> sv/hlfd_checker.sv
// Port-level checker for the host link frame deframer, with its bind.
`default_nettype none

module hlfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   import hlfd_pkg::*;

   logic req_accept;
   assign req_accept = req_tvalid && req_tready;

   // A stalled result transaction must be held unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // A fresh result only follows an accepted received byte.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_accept && req_tuser == FUNC_BYTE))
      else $error("result without a received byte");

   // Payload transactions carry no status or length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[23:8] == 16'd0)
      else $error("payload transaction with status bits set");

   // Status transactions carry a known code, and a length only when the frame was good.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == 8'd0 && rsp_tdata[23:20] == 4'd0
         && rsp_tdata[11:8] <= ST_DCS
         && (rsp_tdata[11:8] == ST_DATA_OK || rsp_tdata[19:12] == 8'd0))
      else $error("malformed status transaction");

endmodule

bind host_link_frame_deframer_top hlfd_checker u_hlfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the host link frame deframer: frame stimulus and result checks.
`timescale 1ns / 1ps

module testbench;
   import hlfd_pkg::*;

   localparam int HuntLimit     = SearchLimitDefault;
   localparam int RandomItems   = 1800;
   localparam int HoldOffCycles = 200;
   localparam int WatchdogLimit = 3000;
   localparam int SettleCycles  = 8;

   typedef enum {
      FK_DATA,
      FK_ACK,
      FK_NACK,
      FK_BAD_INV,
      FK_BAD_LCS,
      FK_BAD_TFI,
      FK_BAD_DCS,
      FK_CUT,
      FK_NO_PAIR
   } frame_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] rx_byte, [15:8] capacity
   logic        req_tuser = 1'b0; // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] payload_byte, [11:8] status, [19:12] frame_length
   logic        rsp_tlast;        // is_last

   // Frame tracker state, mirroring the parser.
   phase_type   ph = PH_IDLE;
   logic        prev_zero = 1'b0;
   logic [6:0]  hunt_count = '0;
   logic [7:0]  len_byte = '0;
   logic [7:0]  bytes_left = '0;
   logic [7:0]  csum = '0;
   logic [7:0]  cap_held = '0;

   result_type  pending_results[$];
   logic [7:0]  link_bytes[$];

   int          errors = 0;
   int          items_in = 0;
   int          results_out = 0;
   int          payload_out = 0;
   int          reads_sent = 0;
   int          status_count[9];
   int          idle_cycles = 0;
   bit          no_gaps = 1'b0;
   bit          hold_off_pending = 1'b0;
   bit          hold_off_active = 1'b0;

   host_link_frame_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic close_read(input status_type st, input logic [7:0] flen);
      result_type r;
      r = '0;
      r.is_last = 1'b1;
      r.status = st;
      r.frame_length = flen;
      pending_results.push_back(r);
      ph = PH_IDLE;
   endtask

   // Advances the frame tracker by one accepted transaction and queues what it yields.
   task automatic track_item(input logic func, input logic [7:0] b, input logic [7:0] cap);
      result_type r;
      logic [7:0] sum;
      r = '0;
      if (func == FUNC_START) begin
         cap_held = cap;
         ph = PH_FIRST;
         prev_zero = 1'b0;
         hunt_count = '0;
         len_byte = '0;
         bytes_left = '0;
         csum = '0;
         return;
      end
      case (ph)
         PH_FIRST: begin
            prev_zero = (b == PreambleZero);
            ph = PH_SEARCH;
         end
         PH_SEARCH: begin
            // The limit wins even over a byte that would complete the start pair.
            if (hunt_count >= HuntLimit) begin
               close_read(ST_NO_PREAMB, 8'd0);
            end else if (b == StartCode && prev_zero) begin
               ph = PH_LEN;
            end else begin
               prev_zero = (b == PreambleZero);
               hunt_count = hunt_count + 7'd1;
            end
         end
         PH_LEN: begin
            len_byte = b;
            ph = (b == 8'h00 || b == 8'hFF) ? PH_INV : PH_LCS;
         end
         PH_INV: begin
            if (b != ~len_byte) close_read(ST_BAD_INV, 8'd0);
            else ph = PH_ACKPOST;
         end
         PH_ACKPOST: begin
            close_read(len_byte == 8'h00 ? ST_ACK : ST_NACK, 8'd0);
         end
         PH_LCS: begin
            sum = len_byte + b;
            if (sum != 8'h00) begin
               close_read(ST_LCS, 8'd0);
            end else begin
               bytes_left = len_byte - 8'd1;
               if (bytes_left > cap_held) close_read(ST_TOO_LONG, 8'd0);
               else ph = PH_TFI;
            end
         end
         PH_TFI: begin
            if (b != TfiHostward) begin
               close_read(ST_TFI, 8'd0);
            end else begin
               csum = TfiHostward;
               ph = (bytes_left == 8'd0) ? PH_DCS : PH_DATA;
            end
         end
         PH_DATA: begin
            csum = csum + b;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) ph = PH_DCS;
            r.payload_byte = b;
            r.status = ST_DATA_OK;
            pending_results.push_back(r);
         end
         PH_DCS: begin
            csum = csum + b;
            if (csum != 8'h00) close_read(ST_DCS, 8'd0);
            else ph = PH_DATAPOST;
         end
         PH_DATAPOST: begin
            close_read(ST_DATA_OK, len_byte - 8'd1);
         end
         default: ph = PH_IDLE;
      endcase
   endtask

   task automatic send_item(input logic func, input logic [7:0] b, input logic [7:0] cap);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {cap, b};
      do @(posedge clock); while (!req_tready);
      track_item(func, b, cap);
      items_in++;
   endtask

   // Fills link_bytes with one frame: a priming byte, noise, the start pair and the body.
   task automatic build_frame(input frame_kind_type kind, input int plen, input int noise);
      logic [7:0] prev_b;
      logic [7:0] b;
      logic [7:0] len;
      logic [7:0] sum;
      int keep;
      link_bytes.delete();
      if (noise == 0 && kind != FK_NO_PAIR && $urandom_range(0, 3) == 0) begin
         // The priming byte itself is the zero of the start pair.
         link_bytes.push_back(PreambleZero);
      end else begin
         prev_b = 8'($urandom_range(0, 255));
         link_bytes.push_back(prev_b);
         repeat (noise) begin
            b = 8'($urandom_range(0, 255));
            if (prev_b == PreambleZero && b == StartCode) b = 8'h5A;
            link_bytes.push_back(b);
            prev_b = b;
         end
         if (kind == FK_NO_PAIR) return;
         link_bytes.push_back(PreambleZero);
      end
      link_bytes.push_back(StartCode);
      case (kind)
         FK_ACK, FK_NACK, FK_BAD_INV: begin
            if (kind == FK_ACK) len = 8'h00;
            else if (kind == FK_NACK) len = 8'hFF;
            else len = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            link_bytes.push_back(len);
            if (kind == FK_BAD_INV) link_bytes.push_back(~len ^ 8'($urandom_range(1, 255)));
            else link_bytes.push_back(~len);
            link_bytes.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            len = 8'(plen + 1);
            link_bytes.push_back(len);
            if (kind == FK_BAD_LCS) link_bytes.push_back(-len + 8'($urandom_range(1, 255)));
            else link_bytes.push_back(-len);
            if (kind == FK_BAD_TFI) link_bytes.push_back(TfiHostward ^ 8'($urandom_range(1, 255)));
            else link_bytes.push_back(TfiHostward);
            sum = TfiHostward;
            repeat (plen) begin
               b = 8'($urandom_range(0, 255));
               sum = sum + b;
               link_bytes.push_back(b);
            end
            if (kind == FK_BAD_DCS) link_bytes.push_back(-sum + 8'($urandom_range(1, 255)));
            else link_bytes.push_back(-sum);
            link_bytes.push_back(8'($urandom_range(0, 255)));
            if (kind == FK_CUT) begin
               keep = $urandom_range(1, link_bytes.size() - 1);
               while (link_bytes.size() > keep) void'(link_bytes.pop_back());
            end
         end
      endcase
   endtask

   task automatic send_read(input logic [7:0] cap, input int trail);
      send_item(FUNC_START, 8'($urandom_range(0, 255)), cap);
      foreach (link_bytes[i]) send_item(FUNC_BYTE, link_bytes[i], 8'($urandom_range(0, 255)));
      repeat (trail) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      reads_sent++;
   endtask

   task automatic test_idle_bytes();
      send_item(FUNC_BYTE, PreambleZero, 8'h00);
      send_item(FUNC_BYTE, StartCode, 8'hFF);
   endtask

   task automatic test_ack_nack();
      build_frame(FK_ACK, 0, 0);
      send_read(8'h00, 0);
      build_frame(FK_NACK, 0, 0);
      send_read(8'hFF, 1);
      build_frame(FK_BAD_INV, 0, 0);
      send_read(8'h10, 0);
   endtask

   task automatic test_zero_length_frame();
      build_frame(FK_DATA, 0, 0);
      send_read(8'h00, 0);
      build_frame(FK_DATA, 1, 0);
      send_read(8'h01, 0);
   endtask

   task automatic test_header_errors();
      build_frame(FK_BAD_LCS, 3, 0);
      send_read(8'hFF, 0);
      build_frame(FK_DATA, 1, 0);
      send_read(8'h00, 0);
      build_frame(FK_BAD_TFI, 2, 0);
      send_read(8'hFF, 0);
      build_frame(FK_BAD_DCS, 2, 0);
      send_read(8'h80, 0);
   endtask

   // Start pair completed one byte before the limit, one byte too late, or not at all.
   task automatic test_search_limit();
      build_frame(FK_DATA, 2, HuntLimit - 2);
      send_read(8'hFF, 0);
      build_frame(FK_DATA, 2, HuntLimit - 1);
      send_read(8'hFF, 0);
      build_frame(FK_NO_PAIR, 0, HuntLimit + 6);
      send_read(8'hFF, 0);
   endtask

   task automatic test_abandoned_read();
      build_frame(FK_CUT, 6, 1);
      send_read(8'hFF, 0);
      build_frame(FK_DATA, 4, 0);
      send_read(8'h04, 2);
   endtask

   task automatic test_longest_frame();
      build_frame(FK_DATA, 253, 0);
      send_read(8'hFF, 0);
      build_frame(FK_DATA, 253, 0);
      send_read(8'd252, 0);
   endtask

   // The receiver stops for a long stretch while a back-to-back frame keeps coming.
   task automatic test_output_backpressure();
      req_tvalid <= 1'b0;
      hold_off_pending = 1'b1;
      while (!hold_off_active) @(posedge clock);
      no_gaps = 1'b1;
      build_frame(FK_DATA, 40, 0);
      send_read(8'hFF, 0);
      no_gaps = 1'b0;
      req_tvalid <= 1'b0;
      while (hold_off_pending) @(posedge clock);
   endtask

   task automatic test_random_frames();
      frame_kind_type kind;
      int r;
      int plen;
      int noise;
      logic [7:0] cap;
      while (items_in < RandomItems) begin
         if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
         r = $urandom_range(0, 99);
         if (r < 50) kind = FK_DATA;
         else if (r < 58) kind = FK_ACK;
         else if (r < 66) kind = FK_NACK;
         else if (r < 71) kind = FK_BAD_INV;
         else if (r < 76) kind = FK_BAD_LCS;
         else if (r < 81) kind = FK_BAD_TFI;
         else if (r < 87) kind = FK_BAD_DCS;
         else if (r < 95) kind = FK_CUT;
         else kind = FK_NO_PAIR;
         r = $urandom_range(0, 99);
         if (r < 70) plen = $urandom_range(0, 8);
         else if (r < 97) plen = $urandom_range(9, 40);
         else plen = $urandom_range(41, 253);
         r = $urandom_range(0, 99);
         if (kind == FK_NO_PAIR) noise = $urandom_range(HuntLimit - 1, HuntLimit + 4);
         else if (r < 70) noise = 0;
         else if (r < 92) noise = $urandom_range(1, 6);
         else noise = $urandom_range(HuntLimit - 4, HuntLimit + 2);
         if (kind == FK_DATA && plen > 0 && $urandom_range(0, 7) == 0) begin
            cap = 8'($urandom_range(0, plen - 1));
         end else begin
            case ($urandom_range(0, 9))
               0, 1: cap = 8'(plen);
               2: cap = 8'hFF;
               default: cap = 8'($urandom_range(plen, 255));
            endcase
         end
         build_frame(kind, plen, noise);
         send_read(cap, $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
      end
      no_gaps = 1'b0;
   endtask

   // Result receiver readiness, including the long hold-off on request.
   initial begin : rsp_ready_gen
      int n;
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            rsp_tready <= 1'b0;
            hold_off_active = 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off_active = 1'b0;
            hold_off_pending = 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            n = gap_len();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   // Result checker: each accepted transaction against the oldest expectation.
   always @(posedge clock) begin : result_check
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.payload_byte = rsp_tdata[7:0];
         got.status = status_type'(rsp_tdata[11:8]);
         got.frame_length = rsp_tdata[19:12];
         got.is_last = rsp_tlast;
         results_out++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, got payload %02h last %0b status %0d length %0d",
                     $time, got.payload_byte, got.is_last, got.status, got.frame_length);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.payload_byte !== want.payload_byte) begin
               $display("%0t: payload_byte expected %02h got %02h",
                        $time, want.payload_byte, got.payload_byte);
               errors++;
            end
            if (got.is_last !== want.is_last) begin
               $display("%0t: is_last expected %0b got %0b", $time, want.is_last, got.is_last);
               errors++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
               errors++;
            end
            if (got.frame_length !== want.frame_length) begin
               $display("%0t: frame_length expected %0d got %0d",
                        $time, want.frame_length, got.frame_length);
               errors++;
            end
            if (want.is_last) status_count[want.status]++;
            else payload_out++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                  $time, WatchdogLimit, pending_results.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : main
      foreach (status_count[i]) status_count[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_bytes();
      test_ack_nack();
      test_zero_length_frame();
      test_header_errors();
      test_search_limit();
      test_abandoned_read();
      test_longest_frame();
      test_output_backpressure();
      test_random_frames();
      req_tvalid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      $display("Covered %0d reads, %0d input transactions, %0d results (%0d payload bytes).",
               reads_sent, items_in, results_out, payload_out);
      $write("Final statuses: ok %0d ack %0d nack %0d inverse %0d preamble %0d",
             status_count[ST_DATA_OK], status_count[ST_ACK], status_count[ST_NACK],
             status_count[ST_BAD_INV], status_count[ST_NO_PREAMB]);
      $display(" lcs %0d long %0d tfi %0d dcs %0d",
               status_count[ST_LCS], status_count[ST_TOO_LONG], status_count[ST_TFI],
               status_count[ST_DCS]);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
